/* rtl/bnzc_pkg.sv */
// Package for the byte ALU with carry, zero and negative flags.
// Holds the operation codes, the flag bundle type and the fixed byte constants.
// No dependencies.
`default_nettype none

package bnzc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned OpW   = 4;

  localparam logic [ByteW-1:0] ByteZero   = 8'h00;
  localparam logic [ByteW-1:0] ByteOne    = 8'h01;
  localparam logic [ByteW-1:0] ByteOnes   = 8'hff;
  localparam logic [ByteW-1:0] PushFixed  = 8'h30;

  // Operation codes carried by req_type.
  typedef enum logic [OpW-1:0] {
    OpLoad  = 4'd0,
    OpAdc   = 4'd1,
    OpSbc   = 4'd2,
    OpInc   = 4'd3,
    OpDec   = 4'd4,
    OpAnd   = 4'd5,
    OpOr    = 4'd6,
    OpEor   = 4'd7,
    OpAsl   = 4'd8,
    OpLsr   = 4'd9,
    OpRol   = 4'd10,
    OpRor   = 4'd11,
    OpCmp   = 4'd12,
    OpBit   = 4'd13,
    OpPushF = 4'd14,
    OpPullF = 4'd15
  } alu_op_e;

  // Processor status flags kept by the block.
  typedef struct packed {
    logic c;
    logic z;
    logic n;
  } flags_t;

endpackage

`default_nettype wire

/* rtl/bnzc_alu.sv */
// Combinational datapath of the byte ALU: one operation on two bytes.
// Depends on bnzc_pkg for the operation codes and the flag bundle.
`default_nettype none

module bnzc_alu
  import bnzc_pkg::*;
(
  input  alu_op_e          op_i,
  input  logic [ByteW-1:0] target_i,
  input  logic [ByteW-1:0] operand_i,
  input  flags_t           flags_i,
  output logic [ByteW-1:0] result_o,
  output logic             write_back_o,
  output flags_t           flags_o
);

  logic [ByteW-1:0] add_b;
  logic             add_cin;
  logic [ByteW:0]   add_sum;
  logic [ByteW-1:0] inc_val;
  logic [ByteW-1:0] dec_val;
  logic [ByteW-1:0] and_val;

  // One shared 8-bit adder serves add, subtract and compare.
  assign add_b   = (op_i == OpAdc) ? operand_i : ~operand_i;
  assign add_cin = (op_i == OpCmp) ? 1'b1 : flags_i.c;
  assign add_sum = {1'b0, target_i} + {1'b0, add_b} + {{ByteW{1'b0}}, add_cin};
  assign inc_val = target_i + ByteOne;
  assign dec_val = target_i + ByteOnes;
  assign and_val = target_i & operand_i;

  // Operation select; Z and N follow the result byte unless noted.
  always_comb begin
    result_o     = ByteZero;
    write_back_o = 1'b1;
    flags_o      = flags_i;
    unique case (op_i)
      OpLoad: result_o = operand_i;
      OpAdc, OpSbc: begin
        result_o  = add_sum[ByteW-1:0];
        flags_o.c = add_sum[ByteW];
      end
      OpInc: result_o = inc_val;
      OpDec: result_o = dec_val;
      OpAnd: result_o = and_val;
      OpOr:  result_o = target_i | operand_i;
      OpEor: result_o = target_i ^ operand_i;
      OpAsl: begin
        result_o  = {target_i[ByteW-2:0], 1'b0};
        flags_o.c = target_i[ByteW-1];
      end
      OpLsr: begin
        result_o  = {1'b0, target_i[ByteW-1:1]};
        flags_o.c = target_i[0];
      end
      OpRol: begin
        result_o  = {target_i[ByteW-2:0], flags_i.c};
        flags_o.c = target_i[ByteW-1];
      end
      OpRor: begin
        result_o  = {flags_i.c, target_i[ByteW-1:1]};
        flags_o.c = target_i[0];
      end
      OpCmp: begin
        write_back_o = 1'b0;
        flags_o.c    = add_sum[ByteW];
        flags_o.z    = (add_sum[ByteW-1:0] == ByteZero);
        flags_o.n    = add_sum[ByteW-1];
      end
      OpBit: begin
        write_back_o = 1'b0;
        flags_o.z    = (and_val == ByteZero);
        flags_o.n    = operand_i[ByteW-1];
      end
      OpPushF: begin
        result_o = PushFixed | {flags_i.n, 5'b00000, flags_i.z, flags_i.c};
      end
      OpPullF: begin
        write_back_o = 1'b0;
        flags_o.c    = operand_i[0];
        flags_o.z    = operand_i[1];
        flags_o.n    = operand_i[ByteW-1];
      end
      default: begin
        write_back_o = 1'b0;
      end
    endcase

    // Every operation from load to rotate right sets Z and N from its result byte; flag push leaves them.
    if (op_i <= OpRor) begin
      flags_o.z = (result_o == ByteZero);
      flags_o.n = result_o[ByteW-1];
    end
  end

endmodule

`default_nettype wire

/* rtl/byte_alu_with_nzc_flags_core.sv */
// Byte ALU with carry, zero and negative flags, 6502 style.
// Pipeline: an input register feeding the ALU, then a result register.
// Throughput: one transaction per cycle unless the output stalls; the flag register is updated as each item
// passes the ALU, so back-to-back items see the flags of their predecessor.
// Reset: rst_ni clears both pipeline valids and the C, Z and N flags to zero.
// Depends on bnzc_pkg and bnzc_alu.
`default_nettype none

module byte_alu_with_nzc_flags_core
  import bnzc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [OpW-1:0]   req_type_i,
  input  logic [ByteW-1:0] target_value_i,
  input  logic [ByteW-1:0] operand_value_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] result_value_o,
  output logic             write_back_o,
  output logic             carry_out_o,
  output logic             zero_out_o,
  output logic             negative_out_o
);

  logic             in_vld_q;
  alu_op_e          op_q;
  logic [ByteW-1:0] tgt_q;
  logic [ByteW-1:0] opnd_q;
  flags_t           flags_q;
  flags_t           flags_d;
  logic             out_vld_q;
  logic [ByteW-1:0] res_q;
  logic [ByteW-1:0] res_d;
  logic             wb_q;
  logic             wb_d;
  flags_t           oflags_q;
  logic             out_free;
  logic             advance;

  // The result register can load when empty or when its transaction leaves.
  assign out_free   = !out_vld_q || out_ready_i;
  assign advance    = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || out_free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q   <= alu_op_e'(req_type_i);
      tgt_q  <= target_value_i;
      opnd_q <= operand_value_i;
    end
  end

  bnzc_alu u_alu (
    .op_i         (op_q),
    .target_i     (tgt_q),
    .operand_i    (opnd_q),
    .flags_i      (flags_q),
    .result_o     (res_d),
    .write_back_o (wb_d),
    .flags_o      (flags_d)
  );

  // Flag state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        flags_q <= flags_d;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q    <= res_d;
      wb_q     <= wb_d;
      oflags_q <= flags_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign result_value_o = res_q;
  assign write_back_o   = wb_q;
  assign carry_out_o    = oflags_q.c;
  assign zero_out_o     = oflags_q.z;
  assign negative_out_o = oflags_q.n;

endmodule

`default_nettype wire

/* rtl/bnzc_checker.sv */
// Port-level checker for the byte ALU core, attached by a bind statement.
// Depends on bnzc_pkg for the field widths.
`default_nettype none

module bnzc_checker
  import bnzc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_o,
  input  logic             out_valid_o,
  input  logic             out_ready_i,
  input  logic [ByteW-1:0] result_value_o,
  input  logic             write_back_o,
  input  logic             carry_out_o,
  input  logic             zero_out_o,
  input  logic             negative_out_o
);

  // A stalled result transaction holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_value_o)
      && $stable(write_back_o) && $stable(carry_out_o)
      && $stable(zero_out_o) && $stable(negative_out_o))
    else $error("stalled result changed");

  // Operations without write-back return a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_back_o |-> result_value_o == '0)
    else $error("non-zero result without write-back");

  // An accepted input transaction has a result on offer once it has passed the input and result registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##2 out_valid_o)
    else $error("result missing two cycles after accept");

  // The input side only stalls because a result waits downstream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

endmodule

bind byte_alu_with_nzc_flags_core bnzc_checker u_bnzc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .result_value_o (result_value_o),
  .write_back_o   (write_back_o),
  .carry_out_o    (carry_out_o),
  .zero_out_o     (zero_out_o),
  .negative_out_o (negative_out_o)
);

`default_nettype wire
